// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/cptb_pkg.sv -----
package cptb_pkg;

    localparam int DATA_W = 16;
    localparam int PSC_W  = 10;

    // request codes
    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_WR_RELOAD  = 2'd1,
        REQ_WR_CONTROL = 2'd2,
        REQ_RD_COUNTER = 2'd3
    } req_type_t;

    // control register layout
    localparam logic [7:0]  CTL_WRITABLE    = 8'hC7;
    localparam int          CTL_CASCADE_BIT = 2;
    localparam int          CTL_IRQ_BIT     = 6;
    localparam int          CTL_ENABLE_BIT  = 7;
    localparam logic [15:0] LANE_LOW_MASK   = 16'h00FF;

    // prescale select codes
    typedef enum logic [1:0] {
        PSC_DIV1    = 2'd0,
        PSC_DIV64   = 2'd1,
        PSC_DIV256  = 2'd2,
        PSC_DIV1024 = 2'd3
    } psc_sel_t;

    // per-timer command from the request decoder
    typedef struct packed {
        logic              tick;
        logic              wr_reload;
        logic              wr_control;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] value;
    } cptb_cmd_t;

    // per-timer event flags for the current tick
    typedef struct packed {
        logic overflow;
        logic irq;
    } cptb_stat_t;

    // last prescaler count of a period
    function automatic logic [PSC_W-1:0] psc_last(input psc_sel_t sel);
        logic [PSC_W-1:0] last;
        unique case (sel)
            PSC_DIV1:    last = 10'd0;
            PSC_DIV64:   last = 10'd63;
            PSC_DIV256:  last = 10'd255;
            PSC_DIV1024: last = 10'd1023;
            default:     last = 10'd0;
        endcase
        return last;
    endfunction

endpackage

// ----- hw/rtl/cptb_timer.sv -----
module cptb_timer
    import cptb_pkg::*;
#(
    parameter int   COUNTER_WIDTH = 16,
    parameter logic CASCADE_EN    = 1'b1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cptb_cmd_t                cmd,
    input  logic                     carry_in,
    output cptb_stat_t               stat,
    output logic [COUNTER_WIDTH-1:0] count_value
);

    logic [DATA_W-1:0]        reload_reg, reload_next;
    logic [7:0]               ctl_reg, ctl_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg, cnt_next;
    psc_sel_t                 psel_reg, psel_next;
    logic [PSC_W-1:0]         pcnt_reg, pcnt_next;
    logic                     over;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= '0;
            ctl_reg    <= '0;
            cnt_reg    <= '0;
            psel_reg   <= PSC_DIV1;
            pcnt_reg   <= '0;
        end else begin
            reload_reg <= reload_next;
            ctl_reg    <= ctl_next;
            cnt_reg    <= cnt_next;
            psel_reg   <= psel_next;
            pcnt_reg   <= pcnt_next;
        end
    end

    always_comb begin
        logic [7:0]               m;
        logic [7:0]               nw;
        logic                     chained;
        logic                     chained_nw;
        logic                     wrap;
        logic                     inc;
        logic                     restart;
        logic [COUNTER_WIDTH-1:0] reload_ext;
        psc_sel_t                 new_sel;

        reload_next = reload_reg;
        ctl_next    = ctl_reg;
        cnt_next    = cnt_reg;
        psel_next   = psel_reg;
        pcnt_next   = pcnt_reg;

        reload_ext = COUNTER_WIDTH'(reload_reg);
        m          = cmd.mask[7:0] & CTL_WRITABLE;
        nw         = (ctl_reg & ~m) | (cmd.value[7:0] & m);
        chained    = CASCADE_EN && ctl_reg[CTL_CASCADE_BIT];
        chained_nw = CASCADE_EN && nw[CTL_CASCADE_BIT];
        restart    = 1'b0;
        new_sel    = PSC_DIV1;

        // tick: prescaler step or carry from below, then count
        wrap = (pcnt_reg >= psc_last(psel_reg));
        inc  = cmd.tick && ctl_reg[CTL_ENABLE_BIT] && (chained ? carry_in : wrap);
        over = inc && (&cnt_reg);
        if (cmd.tick && ctl_reg[CTL_ENABLE_BIT] && !chained) begin
            pcnt_next = wrap ? '0 : PSC_W'(pcnt_reg + 10'd1);
        end
        if (inc) begin
            cnt_next = over ? reload_ext : COUNTER_WIDTH'(cnt_reg + 1'b1);
        end

        if (cmd.wr_reload) begin
            reload_next = (reload_reg & ~cmd.mask) | (cmd.value & cmd.mask);
        end

        if (cmd.wr_control) begin
            ctl_next = nw;
            // prescale select only moves when the low lane is written
            if ((cmd.mask & LANE_LOW_MASK) != '0) begin
                if ((nw[1:0] != 2'd0) && !chained_nw) begin
                    new_sel = psc_sel_t'(nw[1:0]);
                end
                if (new_sel != psel_reg) begin
                    psel_next = new_sel;
                    restart   = 1'b1;
                end
            end
            // start: load from reload
            if (!ctl_reg[CTL_ENABLE_BIT] && nw[CTL_ENABLE_BIT]) begin
                cnt_next = reload_ext;
                restart  = 1'b1;
            end
            if (restart && nw[CTL_ENABLE_BIT] && !chained_nw) begin
                pcnt_next = '0;
            end
        end
    end

    assign stat.overflow = over;
    assign stat.irq      = over && ctl_reg[CTL_IRQ_BIT];
    assign count_value   = cnt_reg;

endmodule

// ----- hw/rtl/cascaded_prescaled_timer_bank.sv -----
// channel | ports                                   | accepted when
// request | s_req_type s_timer_index s_write_mask   | s_valid && s_ready
//         | s_write_value                           |
// result  | m_read_data m_irq_pulses                | m_valid && m_ready
//         | m_overflow_pulses                       |
//
// one request per cycle sustained while results are taken; a taken request passes
// through the request register, then the bank update and result register
// aresetn (synchronous, active low) clears every timer, reload and control
// register and empties both registers
// a stalled result holds the result register; the request register still
// takes one more request behind it
module cascaded_prescaled_timer_bank
    import cptb_pkg::*;
#(
    parameter int NUM_TIMERS    = 4,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [1:0]        s_timer_index,
    input  logic [DATA_W-1:0] s_write_mask,
    input  logic [DATA_W-1:0] s_write_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_data,
    output logic [3:0]        m_irq_pulses,
    output logic [3:0]        m_overflow_pulses
);

    // request register
    logic              in_vld_reg, in_vld_next;
    req_type_t         req_reg;
    logic [1:0]        idx_reg;
    logic [DATA_W-1:0] mask_reg;
    logic [DATA_W-1:0] val_reg;

    // result register
    logic              out_vld_reg, out_vld_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic [3:0]        irq_reg, irq_next;
    logic [3:0]        ovf_reg, ovf_next;

    logic advance;
    logic fire;
    logic take;

    // per-timer wiring
    cptb_cmd_t                cmd   [NUM_TIMERS];
    cptb_stat_t               stat  [NUM_TIMERS];
    logic [COUNTER_WIDTH-1:0] cnt   [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]    carry;

    // the result register frees up when empty or taken this cycle
    assign advance = !out_vld_reg || m_ready;
    assign fire    = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;
    assign take    = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (take) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (fire) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg  <= req_type_t'(s_req_type);
            idx_reg  <= s_timer_index;
            mask_reg <= s_write_mask;
            val_reg  <= s_write_value;
        end
        if (fire) begin
            rd_reg  <= rd_next;
            irq_reg <= irq_next;
            ovf_reg <= ovf_next;
        end
    end

    // the bank: overflow of each timer ripples as carry into its neighbor
    assign carry[0] = 1'b0;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_timer
        logic hit;
        assign hit = (32'(idx_reg) == g);

        assign cmd[g].tick       = fire && (req_reg == REQ_TICK);
        assign cmd[g].wr_reload  = fire && (req_reg == REQ_WR_RELOAD) && hit;
        assign cmd[g].wr_control = fire && (req_reg == REQ_WR_CONTROL) && hit;
        assign cmd[g].mask       = mask_reg;
        assign cmd[g].value      = val_reg;

        // timer 0 has nothing below it to cascade from
        cptb_timer #(
            .COUNTER_WIDTH (COUNTER_WIDTH),
            .CASCADE_EN    (g != 0)
        ) u_timer (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd[g]),
            .carry_in    (carry[g]),
            .stat        (stat[g]),
            .count_value (cnt[g])
        );

        // the top timer has no upper neighbor to carry into
        if (g + 1 < NUM_TIMERS) begin : g_carry
            assign carry[g+1] = stat[g].overflow;
        end
    end

    // only the lower four timers report pulses
    for (genvar p = 0; p < 4; p++) begin : g_pulse
        if (p < NUM_TIMERS) begin : g_live
            assign irq_next[p] = stat[p].irq;
            assign ovf_next[p] = stat[p].overflow;
        end else begin : g_none
            assign irq_next[p] = 1'b0;
            assign ovf_next[p] = 1'b0;
        end
    end

    // counter read; an index with no timer reads zero
    always_comb begin
        rd_next = '0;
        if (req_reg == REQ_RD_COUNTER) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (32'(idx_reg) == i) begin
                    rd_next = DATA_W'(cnt[i]);
                end
            end
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_read_data       = rd_reg;
    assign m_irq_pulses      = irq_reg;
    assign m_overflow_pulses = ovf_reg;

endmodule

// ----- hw/rtl/cptb_checker.sv -----
`include "assert_macros.svh"

module cptb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_req_type,
    input logic [1:0]  s_timer_index,
    input logic [15:0] s_write_mask,
    input logic [15:0] s_write_value,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_read_data,
    input logic [3:0]  m_irq_pulses,
    input logic [3:0]  m_overflow_pulses
);

    // a held result keeps its payload
    `ASSERT_CLK(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_irq_pulses) && $stable(m_overflow_pulses), "result changed while stalled")

    // an interrupt pulse always comes with its overflow pulse
    `ASSERT_CLK(a_irq_sub, aclk, aresetn, m_valid |-> (m_irq_pulses & ~m_overflow_pulses) == 4'd0, "irq without overflow")

    // read data and tick pulses never share a result
    `ASSERT_CLK(a_rd_excl, aclk, aresetn, m_valid && (m_read_data != 16'd0) |-> (m_overflow_pulses == 4'd0), "read data on a tick result")

    // reset empties the result register
    `ASSERT_CLK_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind cascaded_prescaled_timer_bank cptb_checker u_cptb_checker (.*);
